@@ rtl/shn_pkg.sv @@
package shn_pkg;

	localparam int NOTE_W = 7;

	typedef enum logic [1:0] {
		REQ_OFF   = 2'd0,
		REQ_ON    = 2'd1,
		REQ_OTHER = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE,
		OP_ROTATE
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              used;
		logic [NOTE_W-1:0] note;
	} entry_t;

	typedef struct packed {
		op_t               op;
		logic [NOTE_W-1:0] note;
	} cell_ctl_t;

	// ins: insert point at or before this cell; hit: matching note at or before
	typedef struct packed {
		logic ins;
		logic hit;
	} link_t;

endpackage

@@ rtl/shn_cell.sv @@
module shn_cell import shn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    left,
	input  entry_t    right,
	input  link_t     link_in,
	output link_t     link_out,
	output entry_t    cur
);

	entry_t cur_q;
	entry_t cur_d;
	logic   ge;
	logic   match;

	assign ge    = !cur_q.used || (ctl.note >= cur_q.note);
	assign match = cur_q.used && (cur_q.note == ctl.note);

	assign link_out.ins = link_in.ins | ge;
	assign link_out.hit = link_in.hit | match;
	assign cur          = cur_q;

	always_comb begin
		cur_d = cur_q;
		case (ctl.op)
			OP_INSERT: begin
				if (link_in.ins) begin
					cur_d = left;
				end else if (ge) begin
					cur_d.used = 1'b1;
					cur_d.note = ctl.note;
				end
			end
			OP_REMOVE: begin
				if (link_in.hit || match) begin
					cur_d = right;
				end
			end
			OP_ROTATE: begin
				cur_d = right;
			end
			default: begin
				cur_d = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else begin
			cur_q <= cur_d;
		end
	end

endmodule

@@ rtl/sorted_held_note_list.sv @@
// channel  | handshake           | fields
// ---------+---------------------+-------------------------------------------------
// request  | start, busy         | req_type, note, velocity
// result   | valid (strobe)      | slot_index, slot_note, slot_used, held_total,
//          |                     | evicted_valid, evicted_note, dropped_new, last_slot
//
// a word is taken on the edge with start high and busy low; the list updates on that edge
// then MAX_NOTES results follow on consecutive cycles, one per slot, while the chain
// rotates by one cell a cycle and comes back to its order after the last one
// so no new word is taken until the last result of the item has gone out
// reset clears every slot and the count; the receiver cannot stall the results
module sorted_held_note_list import shn_pkg::*; #(
	parameter int MAX_NOTES = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        req_type,
	input  logic [NOTE_W-1:0] note,
	input  logic [NOTE_W-1:0] velocity,
	output logic              valid,
	output logic [1:0]        slot_index,
	output logic [NOTE_W-1:0] slot_note,
	output logic              slot_used,
	output logic [1:0]        held_total,
	output logic              evicted_valid,
	output logic [NOTE_W-1:0] evicted_note,
	output logic              dropped_new,
	output logic              last_slot
);

	localparam int CNT_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int TOT_W = $clog2(MAX_NOTES + 1);

	state_t            state_q;
	state_t            state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [TOT_W-1:0]  count_q;
	logic              evicted_valid_q;
	logic [NOTE_W-1:0] evicted_note_q;
	logic              dropped_q;

	logic              accept;
	logic              is_on;
	logic              is_off;
	logic              at_last;
	logic              full;
	logic              do_drop;
	logic              do_evict;
	cell_ctl_t         ctl;
	entry_t            ent [MAX_NOTES];
	link_t             lnk [MAX_NOTES+1];
	logic [CNT_W+1:0]  idx_wide;
	logic [TOT_W+1:0]  tot_wide;

	assign accept  = start && (state_q == ST_IDLE);
	assign is_on   = (req_type == REQ_ON) && (velocity != '0);
	assign is_off  = (req_type == REQ_OFF) || ((req_type == REQ_ON) && (velocity == '0));
	assign at_last = (cnt_q == CNT_W'(MAX_NOTES - 1));
	assign full    = ent[MAX_NOTES-1].used;
	assign do_drop  = is_on && !lnk[MAX_NOTES].ins;
	assign do_evict = is_on && full && lnk[MAX_NOTES].ins;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (at_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		valid    = 1'b0;
		ctl.op   = OP_HOLD;
		ctl.note = note;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (is_on) begin
						ctl.op = OP_INSERT;
					end else if (is_off) begin
						ctl.op = OP_REMOVE;
					end
				end
			end
			ST_EMIT: begin
				busy   = 1'b1;
				valid  = 1'b1;
				ctl.op = OP_ROTATE;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	assign lnk[0] = '0;

	for (genvar i = 0; i < MAX_NOTES; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;

		if (i == 0) begin : g_first
			assign left_e = '0;
		end else begin : g_mid
			assign left_e = ent[i-1];
		end

		// the last cell wraps to the head while rotating, else fills with an empty slot
		if (i == MAX_NOTES - 1) begin : g_tail
			assign right_e = (ctl.op == OP_ROTATE) ? ent[0] : '0;
		end else begin : g_body
			assign right_e = ent[i+1];
		end

		shn_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.left     (left_e),
			.right    (right_e),
			.link_in  (lnk[i]),
			.link_out (lnk[i+1]),
			.cur      (ent[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			count_q         <= '0;
			evicted_valid_q <= 1'b0;
			evicted_note_q  <= '0;
			dropped_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q           <= '0;
				evicted_valid_q <= do_evict;
				evicted_note_q  <= do_evict ? ent[MAX_NOTES-1].note : '0;
				dropped_q       <= do_drop;
				if (is_on && !do_drop && !full) begin
					count_q <= count_q + TOT_W'(1);
				end else if (is_off && lnk[MAX_NOTES].hit) begin
					count_q <= count_q - TOT_W'(1);
				end
			end else if (state_q == ST_EMIT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	assign idx_wide = (CNT_W+2)'(cnt_q);
	assign tot_wide = (TOT_W+2)'(count_q);

	assign slot_index    = idx_wide[1:0];
	assign slot_used     = ent[0].used;
	assign slot_note     = ent[0].used ? ent[0].note : '0;
	assign held_total    = tot_wide[1:0];
	assign evicted_valid = evicted_valid_q;
	assign evicted_note  = evicted_note_q;
	assign dropped_new   = dropped_q;
	assign last_slot     = valid && at_last;

endmodule

@@ rtl/shn_check.sv @@
module shn_check import shn_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              valid,
	input logic [1:0]        slot_index,
	input logic [NOTE_W-1:0] slot_note,
	input logic              slot_used,
	input logic              last_slot
);

	a_strobe_busy : assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy)
		else $error("result strobe outside a busy period");

	a_first_slot : assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> valid && (slot_index == 2'd0))
		else $error("accepted word not followed by slot zero");

	a_slot_step : assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_slot |=> valid && (slot_index == 2'($past(slot_index) + 2'd1)))
		else $error("slot results not consecutive");

	a_empty_tail : assert property (@(posedge clk) disable iff (!arst_n)
		valid && !slot_used && !last_slot |=> !slot_used)
		else $error("occupied slot after an empty one");

	a_empty_zero : assert property (@(posedge clk) disable iff (!arst_n)
		valid && !slot_used |-> (slot_note == '0))
		else $error("empty slot shows a nonzero note");

endmodule

bind sorted_held_note_list shn_check u_shn_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.valid      (valid),
	.slot_index (slot_index),
	.slot_note  (slot_note),
	.slot_used  (slot_used),
	.last_slot  (last_slot)
);
